// File: src/lcc_pkg.sv
// Shared types and constants for the lane crossing counter.
// Holds the lane count, the per-lane state record, the item and register codes
// and the controller state type. It depends on nothing.
package lcc_pkg;

    localparam int LANES       = 10;
    localparam int LANE_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;

    localparam int LANE_W      = 4;
    localparam int AREA_W      = 27;
    localparam int YMOM_W      = 36;
    localparam int ROW_W       = 10;
    localparam int BAND_W      = 9;
    localparam int MARGIN_W    = 8;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 27;
    localparam int ZONE_W      = 12;

    localparam int DIV_STEPS   = YMOM_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [ROW_W-1:0]   ROW_MAX     = 10'd511;
    localparam logic [BAND_W-1:0]  ROW_MAX_B   = 9'd511;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [BAND_W-1:0]   BAND_TOP_RST    = 9'd10;
    localparam logic [BAND_W-1:0]   BAND_BOTTOM_RST = 9'd20;
    localparam logic [MARGIN_W-1:0] EDGE_MARGIN_RST = 8'd18;
    localparam logic [AREA_W-1:0]   AREA_MIN_RST    = 27'd400;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EDGE_MARGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN    = 2'd3;

    // Item kinds
    localparam logic KIND_OBS    = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef struct packed {
        logic signed [ROW_W-1:0] last_row;
        logic signed [ROW_W-1:0] prior_row;
        logic                    latched;
    } lane_state_t;

    localparam int LANE_STATE_W = $bits(lane_state_t);

    localparam lane_state_t LANE_STATE_RST = '{
        last_row:  '1,
        prior_row: '0,
        latched:   1'b0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

endpackage

// File: src/lane_crossing_counter.sv
// Lane crossing counter top level: controller, serial divider and counters.
// Depends on lcc_pkg and on lcc_ram, which holds the per-lane state.
//
// Counts objects crossing a horizontal band in LANES lanes. An observation
// item carries one lane's area and vertical moment for a frame; a report item
// returns both totals and clears them. Every item gives exactly one result.
// An observation for a valid lane whose area exceeds area_min passes through
// the restoring divider, which forms the row one quotient bit per cycle; the
// lane's state is read from the state RAM as the item is accepted. A done
// state then updates the lane, writes it back and loads the output register.
// Any other item goes straight to the done state. The done state waits while
// a full output register waits for m_ready, and the next item is accepted in
// the cycle after the result is loaded. The block works on one item at a
// time; a finished result sits in the output register while the next item
// is accepted. Lane state comes out of reset at once through per-lane valid
// bits, so there is no clearing pass. The user must write configuration through
// cfg_wr_en, cfg_index and cfg_wdata only while no item is in flight; the
// block itself does not enforce this.
module lane_crossing_counter
    import lcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [LANE_W-1:0]     s_lane,
    input  logic [AREA_W-1:0]     s_area_sum,
    input  logic [YMOM_W-1:0]     s_y_moment_sum,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COUNT_W-1:0]    m_entry_total,
    output logic [COUNT_W-1:0]    m_exit_total,
    output logic                  m_entry_seen,
    output logic                  m_exit_seen
);

    // Configuration
    logic [BAND_W-1:0]   band_top_reg;
    logic [BAND_W-1:0]   band_bottom_reg;
    logic [MARGIN_W-1:0] edge_margin_reg;
    logic [AREA_W-1:0]   area_min_reg;

    // Control
    ctrl_state_t         state_reg, state_next;
    logic                in_fire;
    logic                div_run;
    logic                done_fire;
    logic                out_free;

    // Item held during its work
    logic                  item_kind_reg;
    logic                  lane_ok_reg;
    logic [LANE_IDX_W-1:0] lane_addr_reg;
    logic                  upd_row_reg;
    logic                  entry_valid_reg;
    logic [LANES-1:0]      valid_reg;

    logic                  lane_ok;
    logic [LANE_IDX_W-1:0] lane_addr;
    logic                  area_big;
    logic                  take_div;

    // Divider
    logic [AREA_W-1:0]    divisor_reg;
    logic [YMOM_W-1:0]    dvd_reg;
    logic [AREA_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [AREA_W:0]      trial;
    logic [AREA_W:0]      diff;
    logic                 trial_ge;

    // Counters
    logic [COUNT_W-1:0] entry_count_reg, entry_count_next;
    logic [COUNT_W-1:0] exit_count_reg, exit_count_next;

    // Output register
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_entry_total_reg;
    logic [COUNT_W-1:0] m_exit_total_reg;
    logic               m_entry_seen_reg;
    logic               m_exit_seen_reg;

    // Lane update
    logic [LANE_STATE_W-1:0] ram_rdata;
    lane_state_t             stored;
    lane_state_t             wb_state;
    logic                    ram_we;
    logic                    ram_re;
    logic [BAND_W-1:0]       room;
    logic                    q_over;
    logic signed [ROW_W-1:0] new_row;
    logic signed [ROW_W-1:0] cur;
    logic signed [ZONE_W-1:0] cur_x;
    logic signed [ZONE_W-1:0] prior_x;
    logic signed [ZONE_W-1:0] top_zone;
    logic signed [ZONE_W-1:0] bot_zone;
    logic                    ext;
    logic                    ent;
    logic                    latched_new;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_top_reg    <= BAND_TOP_RST;
            band_bottom_reg <= BAND_BOTTOM_RST;
            edge_margin_reg <= EDGE_MARGIN_RST;
            area_min_reg    <= AREA_MIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BAND_TOP:    band_top_reg    <= cfg_wdata[BAND_W-1:0];
                REG_BAND_BOTTOM: band_bottom_reg <= cfg_wdata[BAND_W-1:0];
                REG_EDGE_MARGIN: edge_margin_reg <= cfg_wdata[MARGIN_W-1:0];
                REG_AREA_MIN:    area_min_reg    <= cfg_wdata[AREA_W-1:0];
                default:         band_top_reg    <= band_top_reg;
            endcase
        end
    end

    //------------------------------------------------------------------
    // Controller
    //------------------------------------------------------------------
    assign out_free  = !m_valid_reg || m_ready;
    assign lane_ok   = (32'(s_lane) < 32'(LANES));
    assign lane_addr = LANE_IDX_W'(s_lane);
    assign area_big  = (s_area_sum > area_min_reg);
    assign take_div  = (s_kind == KIND_OBS) && lane_ok && area_big;
    assign in_fire   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = take_div ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg == '0) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        div_run   = 1'b0;
        done_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_DIV:  div_run   = 1'b1;
            ST_DONE: done_fire = out_free;
            default: s_ready   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the item; the state RAM read is issued in the same cycle
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_kind_reg   <= s_kind;
            lane_ok_reg     <= lane_ok;
            lane_addr_reg   <= lane_addr;
            upd_row_reg     <= area_big;
            entry_valid_reg <= lane_ok && valid_reg[lane_addr];
        end
    end

    //------------------------------------------------------------------
    // Restoring divider: one quotient bit per cycle, quotient shifts into dvd
    //------------------------------------------------------------------
    assign trial    = {rem_reg, dvd_reg[YMOM_W-1]};
    assign trial_ge = (trial >= {1'b0, divisor_reg});
    assign diff     = trial - {1'b0, divisor_reg};

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            divisor_reg <= s_area_sum;
            dvd_reg     <= s_y_moment_sum;
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (div_run) begin
            rem_reg     <= trial_ge ? diff[AREA_W-1:0] : trial[AREA_W-1:0];
            dvd_reg     <= {dvd_reg[YMOM_W-2:0], trial_ge};
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Lane state RAM; the FSM keeps reads and write-backs apart in time
    //------------------------------------------------------------------
    assign ram_re = in_fire && (s_kind == KIND_OBS) && lane_ok;
    assign ram_we = done_fire && (item_kind_reg == KIND_OBS) && lane_ok_reg;

    lcc_ram #(
        .WIDTH (LANE_STATE_W),
        .DEPTH (LANES)
    ) u_lane_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (lane_addr_reg),
        .wdata (wb_state),
        .re    (ram_re),
        .raddr (lane_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ram_we) begin
            valid_reg[lane_addr_reg] <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Crossing decision
    //------------------------------------------------------------------
    assign stored  = entry_valid_reg ? lane_state_t'(ram_rdata) : LANE_STATE_RST;
    assign room    = ROW_MAX_B - band_top_reg;
    assign q_over  = (dvd_reg > YMOM_W'(room));
    assign new_row = q_over ? ROW_MAX
                            : ROW_W'({1'b0, band_top_reg} + {1'b0, dvd_reg[BAND_W-1:0]});
    assign cur     = upd_row_reg ? new_row : stored.last_row;

    assign cur_x    = {{(ZONE_W-ROW_W){cur[ROW_W-1]}}, cur};
    assign prior_x  = {{(ZONE_W-ROW_W){stored.prior_row[ROW_W-1]}}, stored.prior_row};
    assign top_zone = $signed({{(ZONE_W-BAND_W){1'b0}}, band_top_reg})
                    + $signed({{(ZONE_W-MARGIN_W){1'b0}}, edge_margin_reg});
    assign bot_zone = $signed({{(ZONE_W-BAND_W){1'b0}}, band_bottom_reg})
                    - $signed({{(ZONE_W-MARGIN_W){1'b0}}, edge_margin_reg});

    // Moving up means the row shrinks
    assign ext = (prior_x > cur_x) && (cur_x < top_zone) && !stored.latched;
    assign ent = (prior_x < cur_x) && (cur_x > bot_zone) && !stored.latched;

    always_comb begin
        latched_new = stored.latched || ext || ent;
        // Re-arm once the row is strictly between the two zones
        if ((cur_x > top_zone) && (cur_x < bot_zone)) begin
            latched_new = 1'b0;
        end
    end

    always_comb begin
        wb_state.last_row  = cur;
        wb_state.prior_row = cur;
        wb_state.latched   = latched_new;
    end

    always_comb begin
        entry_count_next = entry_count_reg;
        exit_count_next  = exit_count_reg;
        if (ent && (entry_count_reg != COUNT_MAX)) begin
            entry_count_next = entry_count_reg + 1'b1;
        end
        if (ext && (exit_count_reg != COUNT_MAX)) begin
            exit_count_next = exit_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
            exit_count_reg  <= '0;
        end else if (done_fire) begin
            if (item_kind_reg == KIND_REPORT) begin
                entry_count_reg <= '0;
                exit_count_reg  <= '0;
            end else if (lane_ok_reg) begin
                entry_count_reg <= entry_count_next;
                exit_count_reg  <= exit_count_next;
            end
        end
    end

    //------------------------------------------------------------------
    // Output register
    //------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_fire) begin
            if (item_kind_reg == KIND_REPORT || !lane_ok_reg) begin
                m_entry_total_reg <= entry_count_reg;
                m_exit_total_reg  <= exit_count_reg;
                m_entry_seen_reg  <= 1'b0;
                m_exit_seen_reg   <= 1'b0;
            end else begin
                m_entry_total_reg <= entry_count_next;
                m_exit_total_reg  <= exit_count_next;
                m_entry_seen_reg  <= ent;
                m_exit_seen_reg   <= ext;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_entry_total = m_entry_total_reg;
    assign m_exit_total  = m_exit_total_reg;
    assign m_entry_seen  = m_entry_seen_reg;
    assign m_exit_seen   = m_exit_seen_reg;

`ifndef SYNTHESIS
    a_we_in_done: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == ST_DONE))
        else $error("state RAM written outside the update cycle");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_run && (div_cnt_reg == '0)) |=> (state_reg == ST_DONE))
        else $error("divider did not hand over to the update");

    a_seen_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_entry_seen_reg && m_exit_seen_reg))
        else $error("one item counted both an entry and an exit");

    a_report_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_fire && (item_kind_reg == KIND_REPORT))
            |=> (m_valid_reg && !m_entry_seen_reg && !m_exit_seen_reg
                 && (entry_count_reg == '0) && (exit_count_reg == '0)))
        else $error("report item left counts or seen flags set");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !s_ready)
        else $error("item accepted while the divider runs");
`endif

endmodule

// File: src/lcc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the per-lane state of the lane crossing counter; no dependencies.
module lcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: verif/lane_crossing_counter_test.sv
// Self-checking testbench for lane_crossing_counter: a directed plan, then random
// lane trajectories under several band settings, each result checked against a
// model or a fixed value. Depends on lcc_pkg and the lane_crossing_counter RTL.
module lane_crossing_counter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lcc_pkg::*;

    localparam logic [AREA_W-1:0] AREA_LIM       = 27'd78336000;
    localparam logic [YMOM_W-1:0] YMOM_LIM       = 36'd37523136000;
    localparam int                BAND_LIM       = 480;
    localparam int                DRAIN_CYCLES   = 40;
    localparam int                WATCHDOG_LIMIT = 2000;
    localparam int                PHASES         = 6;
    localparam int                PHASE_ITEMS    = 250;

    typedef struct packed {
        logic              kind;
        logic [LANE_W-1:0] lane;
        logic [AREA_W-1:0] area;
        logic [YMOM_W-1:0] ymom;
    } lane_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_total;
        logic [COUNT_W-1:0] exit_total;
        logic               entry_seen;
        logic               exit_seen;
    } tally_t;

    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  fixed;
        lane_item_t            item;
        tally_t                want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_kind = 1'b0;
    logic [LANE_W-1:0]     s_lane = '0;
    logic [AREA_W-1:0]     s_area_sum = '0;
    logic [YMOM_W-1:0]     s_y_moment_sum = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [COUNT_W-1:0]    m_entry_total;
    logic [COUNT_W-1:0]    m_exit_total;
    logic                  m_entry_seen;
    logic                  m_exit_seen;

    lane_crossing_counter dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_lane         (s_lane),
        .s_area_sum     (s_area_sum),
        .s_y_moment_sum (s_y_moment_sum),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_total  (m_entry_total),
        .m_exit_total   (m_exit_total),
        .m_entry_seen   (m_entry_seen),
        .m_exit_seen    (m_exit_seen)
    );

    // model copy of the registers and the lane state
    logic [BAND_W-1:0]       cfg_top    = BAND_TOP_RST;
    logic [BAND_W-1:0]       cfg_bottom = BAND_BOTTOM_RST;
    logic [MARGIN_W-1:0]     cfg_margin = EDGE_MARGIN_RST;
    logic [AREA_W-1:0]       cfg_area_min = AREA_MIN_RST;
    logic signed [ROW_W-1:0] lane_row  [LANES];
    logic signed [ROW_W-1:0] lane_prev [LANES];
    logic                    lane_latched [LANES];
    logic [COUNT_W-1:0]      entry_tally = '0;
    logic [COUNT_W-1:0]      exit_tally = '0;

    tally_t    awaited_totals [$];
    plan_row_t plan [$];
    int        walk_pos [LANES];
    bit        walk_down [LANES];
    bit        idle_on = 1'b0;
    int        failures = 0;
    int        stall_left = 0;
    int        idle_cycles = 0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic tally_t count_crossing(lane_item_t it);
        tally_t          r;
        int              top_zone;
        int              bot_zone;
        int              cur;
        int              motion;
        longint unsigned quo;
        longint unsigned room;
        r = '0;
        if (it.kind == KIND_REPORT) begin
            r.entry_total = entry_tally;
            r.exit_total = exit_tally;
            entry_tally = '0;
            exit_tally = '0;
            return r;
        end
        if (it.lane < LANES) begin
            top_zone = int'(cfg_top) + int'(cfg_margin);
            bot_zone = int'(cfg_bottom) - int'(cfg_margin);
            if (it.area > cfg_area_min) begin
                quo = 64'(it.ymom) / 64'(it.area);
                room = 64'(ROW_MAX) - 64'(cfg_top);
                if (quo > room) begin
                    lane_row[it.lane] = ROW_MAX;
                end else begin
                    lane_row[it.lane] = ROW_W'(int'(cfg_top) + int'(quo));
                end
            end
            cur = int'(lane_row[it.lane]);
            motion = int'(lane_prev[it.lane]) - cur;
            // exit is tested first, so it wins the latch
            if (motion > 0 && cur < top_zone && !lane_latched[it.lane]) begin
                if (exit_tally != COUNT_MAX) exit_tally = exit_tally + 1'b1;
                lane_latched[it.lane] = 1'b1;
                r.exit_seen = 1'b1;
            end
            if (motion < 0 && cur > bot_zone && !lane_latched[it.lane]) begin
                if (entry_tally != COUNT_MAX) entry_tally = entry_tally + 1'b1;
                lane_latched[it.lane] = 1'b1;
                r.entry_seen = 1'b1;
            end
            if (cur > top_zone && cur < bot_zone) lane_latched[it.lane] = 1'b0;
            lane_prev[it.lane] = lane_row[it.lane];
        end
        r.entry_total = entry_tally;
        r.exit_total = exit_tally;
        return r;
    endfunction

    function automatic logic [YMOM_W-1:0] rand_ymom();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return YMOM_W'(v % (64'(YMOM_LIM) + 64'd1));
    endfunction

    function automatic void plan_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row = '0;
        row.is_reg = 1'b1;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    function automatic void plan_item(logic kind, logic [LANE_W-1:0] lane,
                                      logic [AREA_W-1:0] area, logic [YMOM_W-1:0] ymom,
                                      logic fixed, tally_t want);
        plan_row_t row;
        row = '0;
        row.item.kind = kind;
        row.item.lane = lane;
        row.item.area = area;
        row.item.ymom = ymom;
        row.fixed = fixed;
        row.want = want;
        plan.push_back(row);
    endfunction

    // One random item: mostly lanes walking up and down through the band,
    // with reports, bad lanes, too-small areas and raw noise mixed in.
    function automatic lane_item_t pick_item();
        lane_item_t       it;
        int               sel;
        int               l;
        int               lo;
        int               hi;
        int               q;
        logic [AREA_W-1:0] a;
        longint unsigned  y;
        it.kind = KIND_OBS;
        it.lane = LANE_W'($urandom_range(0, LANES - 1));
        it.area = AREA_W'($urandom_range(0, AREA_LIM));
        it.ymom = rand_ymom();
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            it.kind = KIND_REPORT;
            it.lane = LANE_W'($urandom);
        end else if (sel < 13) begin
            it.lane = LANE_W'($urandom_range(LANES, 15));
        end else if (sel < 20) begin
            // raw noise, fields as drawn
        end else if (sel < 30) begin
            it.area = AREA_W'($urandom_range(0, cfg_area_min));
        end else begin
            l = int'(it.lane);
            lo = int'(cfg_top);
            hi = int'(cfg_bottom) + int'(cfg_margin) + 20;
            if (hi < lo + 40) hi = lo + 40;
            if (hi > ROW_MAX) hi = ROW_MAX;
            if (walk_down[l]) walk_pos[l] += $urandom_range(4, 50);
            else walk_pos[l] -= $urandom_range(4, 50);
            if (walk_pos[l] >= hi) begin
                walk_pos[l] = hi;
                walk_down[l] = 1'b0;
            end
            if (walk_pos[l] <= lo) begin
                walk_pos[l] = lo;
                walk_down[l] = 1'b1;
            end
            q = walk_pos[l] - lo;
            if (cfg_area_min >= AREA_LIM) a = AREA_LIM;
            else if ($urandom_range(0, 9) == 0) a = AREA_W'($urandom_range(cfg_area_min + 1, AREA_LIM));
            else a = AREA_W'(32'(cfg_area_min) + 32'd1 + $urandom_range(0, 3000));
            y = 64'(q) * 64'(a) + 64'($urandom_range(0, a - 1));
            if (y > 64'(YMOM_LIM)) y = 64'(YMOM_LIM);
            it.area = a;
            it.ymom = YMOM_W'(y);
        end
        return it;
    endfunction

    function automatic void note_failure(string what);
        failures++;
        if (failures <= 10) $display("%t: %s", $realtime, what);
    endfunction

    // Hold the sender until every awaited result has come, then let the block settle.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (awaited_totals.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_BAND_TOP:    cfg_top = data[BAND_W-1:0];
            REG_BAND_BOTTOM: cfg_bottom = data[BAND_W-1:0];
            REG_EDGE_MARGIN: cfg_margin = data[MARGIN_W-1:0];
            REG_AREA_MIN:    cfg_area_min = data[AREA_W-1:0];
            default:         ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_item(lane_item_t it, logic fixed, tally_t want);
        int     gap;
        tally_t predicted;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= it.kind;
        s_lane <= it.lane;
        s_area_sum <= it.area;
        s_y_moment_sum <= it.ymom;
        do @(posedge aclk); while (!s_ready);
        predicted = count_crossing(it);
        awaited_totals.push_back(fixed ? want : predicted);
    endtask

    always @(posedge aclk) begin : ready_gen
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : result_check
        tally_t got;
        tally_t want;
        if (aresetn && m_valid && m_ready) begin
            got.entry_total = m_entry_total;
            got.exit_total = m_exit_total;
            got.entry_seen = m_entry_seen;
            got.exit_seen = m_exit_seen;
            if (awaited_totals.size() == 0) begin
                note_failure($sformatf("unexpected result: entry %0d exit %0d seen %b/%b",
                    got.entry_total, got.exit_total, got.entry_seen, got.exit_seen));
            end else begin
                want = awaited_totals.pop_front();
                if (got.entry_total !== want.entry_total || got.exit_total !== want.exit_total
                    || got.entry_seen !== want.entry_seen || got.exit_seen !== want.exit_seen)
                begin
                    note_failure($sformatf(
                        "mismatch: expected entry %0d exit %0d seen %b/%b, got %0d %0d %b/%b",
                        want.entry_total, want.exit_total, want.entry_seen, want.exit_seen,
                        got.entry_total, got.exit_total, got.entry_seen, got.exit_seen));
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int     p;
        int     k;
        int     top;
        int     bottom;
        int     margin;
        int     amin;
        tally_t none;
        none = '0;
        for (k = 0; k < LANES; k++) begin
            lane_row[k] = '1;
            lane_prev[k] = '0;
            lane_latched[k] = 1'b0;
        end

        // reset values: top 10, bottom 20, margin 18, area above 400
        plan_item(KIND_REPORT, 4'd0, 27'd0, 36'd0, 1'b1, none);
        // first look at a lane with too small an area counts an exit
        plan_item(KIND_OBS, 4'd0, 27'd0, 36'd0, 1'b1, {16'd0, 16'd1, 1'b0, 1'b1});
        plan_item(KIND_OBS, 4'd15, AREA_LIM, YMOM_LIM, 1'b1, {16'd0, 16'd1, 1'b0, 1'b0});
        plan_item(KIND_OBS, 4'd10, 27'd401, 36'd1000, 1'b1, {16'd0, 16'd1, 1'b0, 1'b0});
        plan_item(KIND_REPORT, 4'd9, AREA_LIM, YMOM_LIM, 1'b1, {16'd0, 16'd1, 1'b0, 1'b0});
        plan_item(KIND_OBS, 4'd1, AREA_LIM, YMOM_LIM, 1'b0, none);
        plan_item(KIND_OBS, 4'd2, 27'd401, YMOM_LIM, 1'b0, none);
        plan_item(KIND_OBS, 4'd3, 27'd400, 36'd12345, 1'b0, none);
        plan_item(KIND_OBS, 4'd9, 27'd401, 36'd0, 1'b0, none);
        plan_item(KIND_OBS, 4'd0, 27'd0, 36'd0, 1'b0, none);
        // wide band: walk lane 4 through entry, re-arm and exit
        plan_reg(REG_BAND_TOP, 27'd100);
        plan_reg(REG_BAND_BOTTOM, 27'd300);
        plan_reg(REG_EDGE_MARGIN, 27'd40);
        plan_reg(REG_AREA_MIN, 27'd1000);
        plan_item(KIND_OBS, 4'd4, 27'd1000, 36'd0, 1'b0, none);
        plan_item(KIND_OBS, 4'd4, 27'd2000, 36'd200000, 1'b0, none);
        plan_item(KIND_OBS, 4'd4, 27'd2000, 36'd341999, 1'b0, none);
        plan_item(KIND_OBS, 4'd4, 27'd2000, 36'd360000, 1'b0, none);
        plan_item(KIND_OBS, 4'd4, 27'd2000, 36'd200000, 1'b0, none);
        plan_item(KIND_OBS, 4'd4, 27'd2000, 36'd60000, 1'b0, none);
        plan_item(KIND_OBS, 4'd4, 27'd0, YMOM_LIM, 1'b0, none);
        plan_item(KIND_REPORT, 4'd0, 27'd0, 36'd0, 1'b0, none);
        // register extremes, row saturation
        plan_reg(REG_BAND_TOP, CFG_DATA_W'(BAND_LIM));
        plan_reg(REG_BAND_BOTTOM, 27'd0);
        plan_reg(REG_EDGE_MARGIN, 27'd0);
        plan_reg(REG_AREA_MIN, 27'd0);
        plan_item(KIND_OBS, 4'd5, 27'd1, 36'd35, 1'b0, none);
        plan_item(KIND_OBS, 4'd5, 27'd0, 36'd0, 1'b0, none);
        plan_item(KIND_OBS, 4'd6, 27'd1, 36'd0, 1'b0, none);
        plan_reg(REG_BAND_TOP, 27'd0);
        plan_reg(REG_BAND_BOTTOM, CFG_DATA_W'(BAND_LIM));
        plan_reg(REG_EDGE_MARGIN, 27'd255);
        plan_reg(REG_AREA_MIN, AREA_LIM);
        plan_item(KIND_OBS, 4'd7, AREA_LIM, YMOM_LIM, 1'b0, none);
        plan_item(KIND_OBS, 4'd8, AREA_LIM, 36'd0, 1'b0, none);
        plan_item(KIND_REPORT, 4'd15, AREA_LIM, YMOM_LIM, 1'b0, none);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;
        foreach (plan[i]) begin
            if (plan[i].is_reg) write_reg(plan[i].idx, plan[i].data);
            else send_item(plan[i].item, plan[i].fixed, plan[i].want);
        end

        for (p = 0; p < PHASES; p++) begin
            case (p)
                2: begin
                    top = 0;
                    bottom = BAND_LIM;
                    margin = 0;
                    amin = 0;
                end
                3, 4: begin
                    top = $urandom_range(0, BAND_LIM);
                    bottom = $urandom_range(0, BAND_LIM);
                    margin = $urandom_range(0, 255);
                    amin = $urandom_range(0, 100000);
                end
                default: begin
                    top = $urandom_range(0, 120);
                    bottom = $urandom_range(200, BAND_LIM);
                    margin = $urandom_range(5, 60);
                    amin = $urandom_range(0, 2000);
                end
            endcase
            write_reg(REG_BAND_TOP, CFG_DATA_W'(top));
            write_reg(REG_BAND_BOTTOM, CFG_DATA_W'(bottom));
            write_reg(REG_EDGE_MARGIN, CFG_DATA_W'(margin));
            write_reg(REG_AREA_MIN, CFG_DATA_W'(amin));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // idle in stretches, none at all in the last phase
                if (k % 40 == 0) idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
                if (p == 2 && k == PHASE_ITEMS / 2) drain_results();
                send_item(pick_item(), 1'b0, none);
            end
        end

        idle_on = 1'b0;
        drain_results();
        if (failures == 0 && awaited_totals.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
src/lcc_pkg.sv
src/lcc_ram.sv
src/lane_crossing_counter.sv
verif/lane_crossing_counter_test.sv
